// File: rtl/hfb_pkg.sv
// ----------------------------------------------------------------------------
// hfb_pkg
// shared constants, lane control struct and helpers for the scaled
// forward/backward block
// ----------------------------------------------------------------------------
package hfb_pkg;

	localparam int MAX_STATES = 4;
	localparam int NUM_LANES  = 4;
	localparam int KCAP       = (MAX_STATES < NUM_LANES) ? MAX_STATES : NUM_LANES;

	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic signed [39:0] SAT_MAX = 40'sh7f_ffff_ffff;
	localparam logic signed [39:0] SAT_MIN = -40'sh80_0000_0000;

	localparam logic [5:0] FRAC_INT = 6'd0;
	localparam logic [5:0] FRAC_VEC = 6'd31;
	localparam logic [5:0] FRAC_RAW = 6'd40;

	localparam logic [2:0] REG_NUM_STATES = 3'd0;
	localparam logic [2:0] REG_INIT       = 3'd1;
	localparam logic [2:0] REG_TROW0      = 3'd2;
	localparam logic [2:0] REG_TROW1      = 3'd3;
	localparam logic [2:0] REG_TROW2      = 3'd4;
	localparam logic [2:0] REG_TROW3      = 3'd5;

	localparam logic CMD_FWD = 1'b0;
	localparam logic CMD_BWD = 1'b1;

	typedef struct packed {
		logic q_step;
		logic mac;
		logic fin;
		logic binit;
		logic zclr;
		logic div_start;
		logic log_raw;
		logic log_vec;
		logic cmd;
		logic sop;
	} lane_ctl_t;

	// uniform starting vector 1/k in UQ1.31
	function automatic logic [31:0] vinit_of(input logic [2:0] k);
		case (k)
			3'd2:    vinit_of = 32'd1073741824;
			3'd3:    vinit_of = 32'd715827882;
			3'd4:    vinit_of = 32'd536870912;
			default: vinit_of = 32'd2147483648;
		endcase
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
		if (v > 41'(SAT_MAX))
			sat40 = SAT_MAX;
		else if (v < 41'(SAT_MIN))
			sat40 = SAT_MIN;
		else
			sat40 = v[39:0];
	endfunction

endpackage

// File: rtl/hfb_log.sv
// ----------------------------------------------------------------------------
// hfb_log
// iterative natural log: normalise, 24 squaring steps, scale by ln 2
// ----------------------------------------------------------------------------
module hfb_log (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [63:0]         x,
	input  logic [5:0]          frac,
	output logic                busy,
	output logic signed [39:0]  result
);
	import hfb_pkg::*;

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_NORM = 3'd1;
	localparam logic [2:0] L_SQ   = 3'd2;
	localparam logic [2:0] L_MUL  = 3'd3;
	localparam logic [2:0] L_RND  = 3'd4;

	logic [2:0]         state_q;
	logic [63:0]        xs_q;
	logic [5:0]         n_q;
	logic [5:0]         f_q;
	logic [31:0]        m_q;
	logic [23:0]        bits_q;
	logic [4:0]         cnt_q;
	logic signed [64:0] prod_q;
	logic signed [39:0] result_q;

	logic [63:0]        sq;
	logic [32:0]        t;
	logic [7:0]         nf;
	logic signed [31:0] lword;
	logic signed [64:0] rnd;

	always_comb begin
		sq    = 64'(m_q) * 64'(m_q);
		t     = sq[63:31];
		nf    = 8'(n_q) - 8'(f_q);
		lword = $signed({nf, bits_q});
		rnd   = prod_q + (65'sd1 <<< 39);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (start) begin
						xs_q    <= x;
						n_q     <= 6'd63;
						f_q     <= frac;
						bits_q  <= '0;
						cnt_q   <= '0;
						state_q <= L_NORM;
					end
				end
				L_NORM: begin
					// coarse then fine leading-zero walk
					if (xs_q != '0 && xs_q[63:48] == '0) begin
						xs_q <= xs_q << 16;
						n_q  <= n_q - 6'd16;
					end else if (xs_q != '0 && !xs_q[63]) begin
						xs_q <= xs_q << 1;
						n_q  <= n_q - 6'd1;
					end else begin
						m_q     <= xs_q[63:32];
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					bits_q <= {bits_q[22:0], t[32]};
					m_q    <= t[32] ? t[32:1] : t[31:0];
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'd23)
						state_q <= L_MUL;
				end
				L_MUL: begin
					prod_q  <= 65'(lword) * $signed({33'd0, LN2_Q32});
					state_q <= L_RND;
				end
				L_RND: begin
					result_q <= 40'($signed(rnd[64:40]));
					state_q  <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != L_IDLE);
	assign result = result_q;

endmodule

// File: rtl/hfb_lane.sv
// ----------------------------------------------------------------------------
// hfb_lane
// one state lane: multiply-accumulate, serial q31 divide and its own log unit
// ----------------------------------------------------------------------------
module hfb_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  hfb_pkg::lane_ctl_t  ctl,
	input  logic                active,
	input  logic [31:0]         e,
	input  logic [15:0]         init,
	input  logic [15:0]         coef,
	input  logic [41:0]         opnd,
	input  logic [31:0]         vinit,
	input  logic [63:0]         sum,
	output logic [63:0]         raw,
	output logic [31:0]         v,
	output logic [41:0]         q,
	output logic signed [39:0]  ln,
	output logic                busy
);
	import hfb_pkg::*;

	logic [31:0] v_q;
	logic [41:0] q_q;
	logic [63:0] acc_q;
	logic [63:0] raw_q;
	logic        d_busy_q;
	logic [63:0] d_r_q;
	logic [31:0] d_q_q;
	logic [4:0]  d_cnt_q;

	logic [63:0] vq_prod;
	logic [57:0] mac_prod;
	logic [59:0] fwd_prod;
	logic [47:0] sop_prod;
	logic [63:0] d_diff;
	logic        d_take;
	logic [31:0] d_qn;
	logic        log_busy;

	always_comb begin
		vq_prod  = 64'(v_q) * 64'(e);
		mac_prod = 58'(coef) * 58'(opnd);
		fwd_prod = 60'(acc_q[49:22]) * 60'(e);
		sop_prod = 48'(init) * 48'(e);
		d_diff   = sum - d_r_q;
		d_take   = (d_r_q >= d_diff);
		d_qn     = {d_q_q[30:0], d_take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q      <= '0;
			d_busy_q <= 1'b0;
		end else begin
			if (ctl.binit)
				v_q <= active ? vinit : '0;
			if (ctl.zclr)
				v_q <= '0;
			if (ctl.div_start) begin
				if (raw_q >= sum) begin
					v_q <= active ? 32'h8000_0000 : '0;
				end else begin
					d_busy_q <= 1'b1;
					d_r_q    <= raw_q;
					d_q_q    <= '0;
					d_cnt_q  <= '0;
				end
			end else if (d_busy_q) begin
				d_r_q   <= d_take ? (d_r_q - d_diff) : (d_r_q << 1);
				d_q_q   <= d_qn;
				d_cnt_q <= d_cnt_q + 5'd1;
				if (d_cnt_q == 5'd30) begin
					d_busy_q <= 1'b0;
					v_q      <= active ? d_qn : '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.q_step) begin
			q_q   <= vq_prod[63:22];
			acc_q <= '0;
		end
		if (ctl.mac)
			acc_q <= acc_q + 64'(mac_prod);
		if (ctl.fin) begin
			if (!active)
				raw_q <= '0;
			else if (ctl.cmd == CMD_BWD)
				raw_q <= acc_q;
			else if (ctl.sop)
				raw_q <= 64'(sop_prod) << 9;
			else
				raw_q <= 64'(fwd_prod);
		end
	end

	hfb_log u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.log_raw | ctl.log_vec),
		.x      (ctl.log_vec ? 64'(v_q) : raw_q),
		.frac   (ctl.log_vec ? FRAC_VEC : FRAC_RAW),
		.busy   (log_busy),
		.result (ln)
	);

	assign raw  = raw_q;
	assign v    = v_q;
	assign q    = q_q;
	assign busy = d_busy_q | log_busy;

endmodule

// File: rtl/hmm_scaled_forward_backward.sv
// ----------------------------------------------------------------------------
// hmm_scaled_forward_backward
// scaled hmm forward/backward recursion in the log domain, four state lanes
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  input    | in_valid / in_stall      | cmd, start_of_pass, emission_0..3
//  output   | out_valid / out_stall    | pass_kind, log_value_0..3, zero_sum
//  config   | cfg_we                   | cfg_index, cfg_data
//
//  one request at a time. forward: the 31-step lane divide racing the sum log,
//  then the vector log (normalise walk, 24 squarings, scale, round); backward:
//  the lane divide and the lane raw log beside the sum log; a backward start
//  first runs ln k; a zero sum skips the divide and the logs
//  arst_n clears control, the kept vector and the log scale; config to defaults
//  in_stall is high while a request is in flight; a finished result may wait
//  in the output register while the next request is taken
// ----------------------------------------------------------------------------
module hmm_scaled_forward_backward (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic                start_of_pass,
	input  logic [31:0]         emission_0,
	input  logic [31:0]         emission_1,
	input  logic [31:0]         emission_2,
	input  logic [31:0]         emission_3,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                pass_kind,
	output logic signed [39:0]  log_value_0,
	output logic signed [39:0]  log_value_1,
	output logic signed [39:0]  log_value_2,
	output logic signed [39:0]  log_value_3,
	output logic                zero_sum,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);
	import hfb_pkg::*;

	// sequencer codes
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_BINIT = 4'd1;
	localparam logic [3:0] ST_BWAIT = 4'd2;
	localparam logic [3:0] ST_Q     = 4'd3;
	localparam logic [3:0] ST_MAC   = 4'd4;
	localparam logic [3:0] ST_FIN   = 4'd5;
	localparam logic [3:0] ST_SUM   = 4'd6;
	localparam logic [3:0] ST_CHK   = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_VLOG  = 4'd9;
	localparam logic [3:0] ST_VWAIT = 4'd10;
	localparam logic [3:0] ST_COMB  = 4'd11;

	// configuration registers
	logic [2:0]  num_states_q;
	logic [63:0] init_q;
	logic [63:0] trow_q [NUM_LANES];

	// per-request state
	logic [3:0]                state_q;
	logic                      cmd_q;
	logic                      sop_q;
	logic [2:0]                k_q;
	logic [31:0]               e_q [NUM_LANES];
	logic [1:0]                idx_q;
	logic [63:0]               sum_q;
	logic                      zero_q;
	logic signed [39:0]        scale_q;

	// output register
	logic                      out_valid_q;
	logic                      pass_kind_q;
	logic signed [39:0]        val_q [NUM_LANES];
	logic                      zero_sum_q;

	// lane wiring
	lane_ctl_t                 ctl;
	logic [NUM_LANES-1:0]      act;
	logic [NUM_LANES-1:0]      lane_busy;
	logic [63:0]               raw_w  [NUM_LANES];
	logic [31:0]               v_w    [NUM_LANES];
	logic [41:0]               q_w    [NUM_LANES];
	logic signed [39:0]        ln_w   [NUM_LANES];
	logic [15:0]               coef_w [NUM_LANES];
	logic [31:0]               emis   [NUM_LANES];

	// merge-side log unit (ln k and ln of the sum)
	logic                      slog_start;
	logic [63:0]               slog_x;
	logic [5:0]                slog_f;
	logic                      slog_busy;
	logic signed [39:0]        slog_res;

	logic [2:0]                k_now;
	logic                      accept;
	logic                      out_free;
	logic signed [39:0]        new_scale;
	logic signed [39:0]        use_scale;
	logic signed [39:0]        val_d  [NUM_LANES];

	assign emis[0] = emission_0;
	assign emis[1] = emission_1;
	assign emis[2] = emission_2;
	assign emis[3] = emission_3;

	// clamp the state count into 1..kcap
	always_comb begin
		if (num_states_q == 3'd0)
			k_now = 3'd1;
		else if (num_states_q > 3'(KCAP))
			k_now = 3'(KCAP);
		else
			k_now = num_states_q;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= 3'd2;
			init_q       <= 64'h0000_0000_4000_4000;
			trow_q[0]    <= 64'h0000_0000_0000_8000;
			trow_q[1]    <= 64'h0000_0000_8000_0000;
			trow_q[2]    <= 64'h0000_8000_0000_0000;
			trow_q[3]    <= 64'h8000_0000_0000_0000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_STATES: num_states_q <= cfg_data[2:0];
				REG_INIT:       init_q       <= cfg_data;
				REG_TROW0:      trow_q[0]    <= cfg_data;
				REG_TROW1:      trow_q[1]    <= cfg_data;
				REG_TROW2:      trow_q[2]    <= cfg_data;
				REG_TROW3:      trow_q[3]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// lane control decode, straight from the sequencer state
	always_comb begin
		ctl           = '0;
		ctl.cmd       = cmd_q;
		ctl.sop       = sop_q;
		ctl.binit     = (state_q == ST_BINIT);
		ctl.q_step    = (state_q == ST_Q);
		ctl.mac       = (state_q == ST_MAC);
		ctl.fin       = (state_q == ST_FIN);
		ctl.zclr      = (state_q == ST_CHK) && (sum_q == '0);
		ctl.div_start = (state_q == ST_CHK) && (sum_q != '0);
		ctl.log_raw   = ctl.div_start && (cmd_q == CMD_BWD);
		ctl.log_vec   = (state_q == ST_VLOG);
	end

	// forward takes column j of row i, backward row j at column i
	always_comb begin
		for (int j = 0; j < NUM_LANES; j++) begin
			if (cmd_q == CMD_BWD)
				coef_w[j] = trow_q[j][16*idx_q +: 16];
			else
				coef_w[j] = trow_q[idx_q][16*j +: 16];
		end
	end

	genvar gj;
	generate
		for (gj = 0; gj < NUM_LANES; gj++) begin : g_lane
			assign act[gj] = (3'(gj) < k_q);
			hfb_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.active (act[gj]),
				.e      (e_q[gj]),
				.init   (init_q[16*gj +: 16]),
				.coef   (coef_w[gj]),
				.opnd   ((cmd_q == CMD_BWD) ? q_w[idx_q] : 42'(v_w[idx_q])),
				.vinit  (vinit_of(k_q)),
				.sum    (sum_q),
				.raw    (raw_w[gj]),
				.v      (v_w[gj]),
				.q      (q_w[gj]),
				.ln     (ln_w[gj]),
				.busy   (lane_busy[gj])
			);
		end
	endgenerate

	// the merge log unit runs ln k at a backward start, ln(sum) otherwise
	assign slog_start = (state_q == ST_BINIT) || ctl.div_start;
	assign slog_x     = (state_q == ST_BINIT) ? 64'(k_q) : sum_q;
	assign slog_f     = (state_q == ST_BINIT) ? FRAC_INT : FRAC_RAW;

	hfb_log u_slog (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (slog_start),
		.x      (slog_x),
		.frac   (slog_f),
		.busy   (slog_busy),
		.result (slog_res)
	);

	// merge: scale update and per-lane log values
	always_comb begin
		if (cmd_q == CMD_FWD && sop_q)
			new_scale = slog_res;
		else
			new_scale = sat40(41'(scale_q) + 41'(slog_res));
		// backward values use the scale from before this step
		use_scale = (cmd_q == CMD_BWD) ? scale_q : new_scale;
		for (int j = 0; j < NUM_LANES; j++) begin
			if (!act[j])
				val_d[j] = '0;
			else if (zero_q)
				val_d[j] = SAT_MIN;
			else if ((cmd_q == CMD_BWD) ? (raw_w[j] == '0) : (v_w[j] == '0))
				val_d[j] = SAT_MIN;
			else
				val_d[j] = sat40(41'(ln_w[j]) + 41'(use_scale));
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result raised out of the merge step, dropped once taken
			if (state_q == ST_COMB && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= (cmd == CMD_BWD && start_of_pass) ? ST_BINIT : ST_Q;
				end
				ST_BINIT: state_q <= ST_BWAIT;
				ST_BWAIT: begin
					if (!slog_busy) begin
						scale_q <= slog_res;
						state_q <= ST_Q;
					end
				end
				ST_Q: state_q <= ST_MAC;
				ST_MAC: begin
					if ({1'b0, idx_q} == k_q - 3'd1)
						state_q <= ST_FIN;
				end
				ST_FIN: state_q <= ST_SUM;
				ST_SUM: begin
					if (idx_q == 2'(NUM_LANES - 1))
						state_q <= ST_CHK;
				end
				ST_CHK:   state_q <= (sum_q == '0) ? ST_COMB : ST_DIV;
				ST_DIV: begin
					if (lane_busy == '0 && !slog_busy)
						state_q <= (cmd_q == CMD_FWD) ? ST_VLOG : ST_COMB;
				end
				ST_VLOG:  state_q <= ST_VWAIT;
				ST_VWAIT: begin
					if (lane_busy == '0)
						state_q <= ST_COMB;
				end
				ST_COMB: begin
					if (out_free) begin
						if (!zero_q)
							scale_q <= new_scale;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture, index counter, sum and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			sop_q <= start_of_pass;
			k_q   <= k_now;
			for (int j = 0; j < NUM_LANES; j++)
				e_q[j] <= (3'(j) < k_now) ? emis[j] : '0;
		end
		case (state_q)
			ST_Q:   idx_q <= '0;
			ST_MAC: idx_q <= idx_q + 2'd1;
			ST_FIN: begin
				idx_q <= '0;
				sum_q <= '0;
			end
			ST_SUM: begin
				sum_q <= sum_q + raw_w[idx_q];
				idx_q <= idx_q + 2'd1;
			end
			ST_CHK: zero_q <= (sum_q == '0);
			ST_COMB: begin
				if (out_free) begin
					pass_kind_q <= cmd_q;
					zero_sum_q  <= zero_q;
					for (int j = 0; j < NUM_LANES; j++)
						val_q[j] <= val_d[j];
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign pass_kind   = pass_kind_q;
	assign log_value_0 = val_q[0];
	assign log_value_1 = val_q[1];
	assign log_value_2 = val_q[2];
	assign log_value_3 = val_q[3];
	assign zero_sum    = zero_sum_q;

	// a result only appears out of the merge step
	a_out_from_comb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_COMB)
		else $error("result raised outside the merge step");

	// the accumulate index never walks past the active lanes
	a_mac_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> {1'b0, idx_q} < k_q)
		else $error("accumulate index beyond state count");

	// a zero-sum result floors lane 0, which is always active
	a_zero_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_sum |-> log_value_0 == SAT_MIN)
		else $error("zero sum without floored value");

	// lanes are never busy while the block waits for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && $past(state_q) == ST_IDLE |-> lane_busy == '0 && !slog_busy)
		else $error("lane still busy while idle");

endmodule
